// ----- design/vpp_pkg.sv -----
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types, register codes and saturation helper for the vertex
// perspective projection block.
// ----------------------------------------------------------------------------
package vpp_pkg;

  // Width of the widened intermediate words (numerators, divisors, remainders)
  localparam int NW = 66;
  // Quotient bits produced by the divider
  localparam int QB = 32;

  localparam logic [2:0] REG_X_SCALE         = 3'd0;
  localparam logic [2:0] REG_Y_SCALE         = 3'd1;
  localparam logic [2:0] REG_Z_SCALE         = 3'd2;
  localparam logic [2:0] REG_Z_OFFSET        = 3'd3;
  localparam logic [2:0] REG_W_SCALE         = 3'd4;
  localparam logic [2:0] REG_CAMERA_DISTANCE = 3'd5;
  localparam logic [2:0] REG_VIEW_W          = 3'd6;
  localparam logic [2:0] REG_VIEW_H          = 3'd7;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [31:0] z_scale;
    logic signed [31:0] z_offset;
    logic signed [31:0] w_scale;
    logic signed [31:0] camera_distance;
    logic [13:0]        view_w;
    logic [13:0]        view_h;
  } vpp_cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } vpp_sat_t;

  // One coordinate on its way to the divider
  typedef struct packed {
    logic [NW-1:0]      n;      // |p| shifted up by the fraction bits
    logic               neg;    // quotient sign
    logic signed [31:0] sv;     // saturated undivided value
    logic               sclip;  // undivided value was clipped
  } vpp_lane_t;

  typedef struct packed {
    vpp_lane_t [2:0] lane;
    logic [NW-1:0]   d;         // |w|
    logic            wz;        // w is zero
  } vpp_rec_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               w_zero;
    logic               saturated;
  } vpp_res_t;

  function automatic vpp_sat_t sat32(input logic signed [NW-1:0] v);
    vpp_sat_t o;
    o.clip = 1'b0;
    o.val  = v[31:0];
    if (!v[NW-1] && (|v[NW-2:31])) begin
      o.clip = 1'b1;
      o.val  = SAT_MAX;
    end else if (v[NW-1] && !(&v[NW-2:31])) begin
      o.clip = 1'b1;
      o.val  = SAT_MIN;
    end
    return o;
  endfunction

endpackage

// ----- design/vpp_fifo.sv -----
// ----------------------------------------------------------------------------
// vpp_fifo
// Small register queue with push/full and pop/empty sides. DEPTH is a power
// of two, at least 2.
// ----------------------------------------------------------------------------
module vpp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not shrink on pop");

  a_pointer_gap: assert property (@(posedge clk) disable iff (rst)
    (!full && !empty) |-> (wptr != rptr))
    else $error("queue pointers collide while partly filled");

endmodule

// ----- design/vpp_front.sv -----
// ----------------------------------------------------------------------------
// vpp_front
// Accept vertices, apply camera offset and projection terms, classify w and
// prepare numerators and divisor for the back end.
// ----------------------------------------------------------------------------
module vpp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  vpp_pkg::vpp_cfg_t  cfg,
  input  logic               push,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output logic               full,
  output vpp_pkg::vpp_rec_t  rec,
  output logic               rec_valid,
  input  logic               rec_ready
);

  import vpp_pkg::*;

  logic               en;
  logic               s0_valid;
  logic               s1_valid;
  logic               s2_valid;
  logic signed [31:0] s0_x;
  logic signed [31:0] s0_y;
  logic signed [32:0] s0_z;
  logic signed [63:0] p_x;
  logic signed [63:0] p_y;
  logic signed [64:0] p_z;
  logic signed [64:0] p_w;
  logic signed [NW-1:0] px_w;
  logic signed [NW-1:0] py_w;
  logic signed [NW-1:0] pz_w;
  logic signed [NW-1:0] w_w;
  vpp_rec_t           rec_next;

  function automatic vpp_lane_t mk_lane(input logic signed [NW-1:0] v, input logic wneg);
    vpp_lane_t     o;
    logic [NW-1:0] m;
    vpp_sat_t      s;
    m       = v[NW-1] ? NW'(-v) : NW'(v);
    s       = sat32(v);
    o.n     = NW'(m << FRAC_BITS);
    o.neg   = v[NW-1] ^ wneg;
    o.sv    = s.val;
    o.sclip = s.clip;
    return o;
  endfunction

  // Advance the whole front unless its last item is blocked by the queue
  assign en        = !(s2_valid && !rec_ready);
  assign full      = !en;
  assign rec_valid = s2_valid;

  assign px_w = NW'(p_x >>> FRAC_BITS);
  assign py_w = NW'(p_y >>> FRAC_BITS);
  assign pz_w = NW'(p_z >>> FRAC_BITS) + NW'(cfg.z_offset);
  assign w_w  = NW'(p_w >>> FRAC_BITS);

  always_comb begin
    rec_next             = '0;
    rec_next.lane[LANE_X] = mk_lane(px_w, w_w[NW-1]);
    rec_next.lane[LANE_Y] = mk_lane(py_w, w_w[NW-1]);
    rec_next.lane[LANE_Z] = mk_lane(pz_w, w_w[NW-1]);
    rec_next.d           = w_w[NW-1] ? NW'(-w_w) : NW'(w_w);
    rec_next.wz          = (w_w == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= push;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x <= vertex_x;
      s0_y <= vertex_y;
      s0_z <= 33'(vertex_z) + 33'(cfg.camera_distance);
      p_x  <= s0_x * cfg.x_scale;
      p_y  <= s0_y * cfg.y_scale;
      p_z  <= s0_z * cfg.z_scale;
      p_w  <= s0_z * cfg.w_scale;
      rec  <= rec_next;
    end
  end

endmodule

// ----- design/vpp_back.sv -----
// ----------------------------------------------------------------------------
// vpp_back
// Pipelined restoring divider for three coordinates over one divisor,
// followed by saturation and the viewport mapping.
// ----------------------------------------------------------------------------
module vpp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  vpp_pkg::vpp_cfg_t cfg,
  input  vpp_pkg::vpp_rec_t rec,
  input  logic              rec_valid,
  output logic              rec_ready,
  output vpp_pkg::vpp_res_t res,
  output logic              res_valid,
  input  logic              res_ready
);

  import vpp_pkg::*;

  typedef struct packed {
    logic [NW-1:0]      r;
    logic [QB-1:0]      nlo;
    logic [QB-1:0]      q;
    logic               ovf;
    logic               neg;
    logic signed [31:0] sv;
    logic               sclip;
  } div_t;

  logic          en;
  logic          valid [0:QB];
  div_t          st    [0:QB][0:2];
  logic [NW-1:0] dv    [0:QB];
  logic          wzs   [0:QB];

  logic               e1_valid;
  logic signed [32:0] e1_vx;
  logic signed [32:0] e1_vy;
  logic signed [31:0] e1_pz;
  logic               e1_clip;
  logic               e1_wz;
  logic               e2_valid;
  logic signed [47:0] e2_tx;
  logic signed [47:0] e2_ty;
  logic signed [31:0] e2_pz;
  logic               e2_clip;
  logic               e2_wz;

  vpp_sat_t           fin [0:2];
  vpp_sat_t           sat_x;
  vpp_sat_t           sat_y;
  logic signed [32:0] one_q;

  function automatic div_t first_step(input vpp_lane_t l, input logic [NW-1:0] d);
    div_t o;
    o.r     = NW'(l.n[NW-1:QB]);
    o.nlo   = l.n[QB-1:0];
    o.q     = '0;
    o.ovf   = (NW'(l.n[NW-1:QB]) >= d);
    o.neg   = l.neg;
    o.sv    = l.sv;
    o.sclip = l.sclip;
    return o;
  endfunction

  function automatic div_t div_step(input div_t s, input logic [NW-1:0] d);
    div_t          o;
    logic [NW-1:0] t;
    o     = s;
    t     = {s.r[NW-2:0], s.nlo[QB-1]};
    o.nlo = {s.nlo[QB-2:0], 1'b0};
    if (t >= d) begin
      o.r = t - d;
      o.q = {s.q[QB-2:0], 1'b1};
    end else begin
      o.r = t;
      o.q = {s.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic vpp_sat_t finish(input div_t s, input logic wz);
    vpp_sat_t o;
    o.clip = 1'b0;
    o.val  = signed'(s.q);
    if (wz) begin
      o.clip = s.sclip;
      o.val  = s.sv;
    end else if (s.ovf) begin
      o.clip = 1'b1;
      o.val  = s.neg ? SAT_MIN : SAT_MAX;
    end else if (s.neg) begin
      if (s.q > 32'h8000_0000) begin
        o.clip = 1'b1;
        o.val  = SAT_MIN;
      end else begin
        o.val = signed'(-s.q);
      end
    end else if (s.q[QB-1]) begin
      o.clip = 1'b1;
      o.val  = SAT_MAX;
    end
    return o;
  endfunction

  // Stall everything behind a result the output queue cannot take
  assign en        = !(e2_valid && !res_ready);
  assign rec_ready = en;
  assign res_valid = e2_valid;
  assign one_q     = 33'(1) <<< FRAC_BITS;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fin[l] = finish(st[QB][l], wzs[QB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        st[0][l] <= first_step(rec.lane[l], rec.d);
      end
      dv[0]  <= rec.d;
      wzs[0] <= rec.wz;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          st[k][l] <= div_step(st[k-1][l], dv[k-1]);
        end
        dv[k]  <= dv[k-1];
        wzs[k] <= wzs[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= valid[QB];
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_vx   <= 33'(fin[LANE_X].val) + one_q;
      e1_vy   <= 33'(fin[LANE_Y].val) + one_q;
      e1_pz   <= fin[LANE_Z].val;
      e1_clip <= fin[LANE_X].clip | fin[LANE_Y].clip | fin[LANE_Z].clip;
      e1_wz   <= wzs[QB];
      e2_tx   <= e1_vx * signed'({1'b0, cfg.view_w});
      e2_ty   <= e1_vy * signed'({1'b0, cfg.view_h});
      e2_pz   <= e1_pz;
      e2_clip <= e1_clip;
      e2_wz   <= e1_wz;
    end
  end

  assign sat_x = sat32(NW'(e2_tx >>> 1));
  assign sat_y = sat32(NW'(e2_ty >>> 1));

  always_comb begin
    res.screen_x  = sat_x.val;
    res.screen_y  = sat_y.val;
    res.depth     = e2_pz;
    res.w_zero    = e2_wz;
    res.saturated = e2_clip | sat_x.clip | sat_y.clip;
  end

endmodule

// ----- design/vertex_perspective_projection.sv -----
// ----------------------------------------------------------------------------
// vertex_perspective_projection
// Perspective projection, divide by w and viewport mapping of a vertex stream
// in signed fixed point, with saturated results.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  vertex in | push / full         | vertex_x, vertex_y, vertex_z
//  result    | pop / empty         | screen_x, screen_y, depth, w_zero, saturated
//  config    | cfg_write           | cfg_index, cfg_data
//
//  One vertex per clock is accepted and one result per clock delivered while
//  the consumer keeps popping; the rate is set by the 32-stage divider
//  pipeline, one quotient bit per stage. An item passes 40 register stages:
//  3 front stages, the middle queue, 35 divider and viewport stages, and the
//  output queue, after which its result can be popped. Reset (rst, synchronous)
//  empties the queues and loads the register defaults. A stalled result holds
//  the back end, a full middle queue holds the front, and full rises only
//  when the front end cannot advance.
// ----------------------------------------------------------------------------
module vertex_perspective_projection #(
  parameter int FRAC_BITS  = 16,
  parameter int MID_DEPTH  = 4,
  parameter int OUT_DEPTH  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] depth,
  output logic               w_zero,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import vpp_pkg::*;

  vpp_cfg_t cfg;
  vpp_rec_t front_rec;
  vpp_rec_t mid_rec;
  vpp_res_t back_res;
  vpp_res_t out_res;
  logic     front_valid;
  logic     mid_full;
  logic     mid_empty;
  logic     back_pop;
  logic     back_valid;
  logic     out_full;

  // Configuration registers; the user writes them only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale         <= 32'sd65536;
      cfg.y_scale         <= 32'sd65536;
      cfg.z_scale         <= 32'sd65536;
      cfg.z_offset        <= -32'sd65536;
      cfg.w_scale         <= 32'sd65536;
      cfg.camera_distance <= 32'sd196608;
      cfg.view_w          <= 14'd640;
      cfg.view_h          <= 14'd480;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_SCALE:         cfg.x_scale         <= cfg_data;
        REG_Y_SCALE:         cfg.y_scale         <= cfg_data;
        REG_Z_SCALE:         cfg.z_scale         <= cfg_data;
        REG_Z_OFFSET:        cfg.z_offset        <= cfg_data;
        REG_W_SCALE:         cfg.w_scale         <= cfg_data;
        REG_CAMERA_DISTANCE: cfg.camera_distance <= cfg_data;
        REG_VIEW_W:          cfg.view_w          <= cfg_data[13:0];
        REG_VIEW_H:          cfg.view_h          <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Front: offset z, multiply, classify w, build numerators
  vpp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .vertex_x  (vertex_x),
    .vertex_y  (vertex_y),
    .vertex_z  (vertex_z),
    .full      (full),
    .rec       (front_rec),
    .rec_valid (front_valid),
    .rec_ready (!mid_full)
  );

  // Decouple front and back so each can stall on its own
  vpp_fifo #(.W($bits(vpp_rec_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_rec),
    .full  (mid_full),
    .pop   (back_pop),
    .dout  (mid_rec),
    .empty (mid_empty)
  );

  // Back: divide by w, saturate, map to viewport
  vpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec       (mid_rec),
    .rec_valid (!mid_empty),
    .rec_ready (back_pop),
    .res       (back_res),
    .res_valid (back_valid),
    .res_ready (!out_full)
  );

  // Hold finished results for the consumer
  vpp_fifo #(.W($bits(vpp_res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .din   (back_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign screen_x  = out_res.screen_x;
  assign screen_y  = out_res.screen_y;
  assign depth     = out_res.depth;
  assign w_zero    = out_res.w_zero;
  assign saturated = out_res.saturated;

endmodule
